// ===== hw/rtl/brk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brk_pkg - shared types and codes for the Brookshear core
// Beat layouts, host modes, opcodes and the byte rotate helper.
// ----------------------------------------------------------------------------
package brk_pkg;

	// host modes
	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;
	localparam logic [1:0] MODE_STEP    = 2'd3;

	// opcodes (0 and C..F halt)
	localparam logic [3:0] OP_LOAD  = 4'h1;
	localparam logic [3:0] OP_LDI   = 4'h2;
	localparam logic [3:0] OP_STORE = 4'h3;
	localparam logic [3:0] OP_MOVE  = 4'h4;
	localparam logic [3:0] OP_ADD   = 4'h5;
	localparam logic [3:0] OP_FADD  = 4'h6;
	localparam logic [3:0] OP_OR    = 4'h7;
	localparam logic [3:0] OP_AND   = 4'h8;
	localparam logic [3:0] OP_XOR   = 4'h9;
	localparam logic [3:0] OP_ROT   = 4'hA;
	localparam logic [3:0] OP_JMP   = 4'hB;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] address;
		logic [7:0] write_data;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] program_counter;
		logic       halted;
		logic       executed;
	} out_beat_t;

	// rotate right by n (0..7)
	function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] n);
		logic [15:0] w;
		w = {v, v} >> n;
		return w[7:0];
	endfunction

endpackage

// ===== hw/rtl/brookshear_cpu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brookshear_cpu_core - 8-bit teaching processor with host access
// 256-byte single-port memory, 16 byte registers, PC and halt flag, driven
// one host beat at a time: write byte, read byte, restart, or step.
// ----------------------------------------------------------------------------
//
//  channel | signals                      | direction | beat
//  --------+------------------------------+-----------+---------------------
//  in      | in_valid, in_stall, in_data  | to core   | host command
//  out     | out_valid, out_stall, out_data | from core | one result/command
//  cfg     | cfg_we, cfg_wdata            | to core   | start address write
//
//  A running step fetches both instruction bytes (F1, F2), decodes (DEC),
//  then reads operands (RB) and executes (EX) as the opcode needs.
//  The single memory port (two fetches plus one data access) and the
//  one-read register file port set the step length.
//  Reset clears PC, halt flag, start address and the per-entry valid bits of
//  memory and register file, so every entry reads as zero until written.
//  A finished result sits in the output register; a new command is taken
//  while it waits, and the core holds in its last state if out is stalled.
// ----------------------------------------------------------------------------
module brookshear_cpu_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  brk_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output brk_pkg::out_beat_t  out_data,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_HRD   = 8'b0000_0010,  // host read data returns
		ST_F1    = 8'b0000_0100,  // first instruction byte returns
		ST_F2    = 8'b0000_1000,  // second byte returns
		ST_DEC   = 8'b0001_0000,  // decode, issue operand read
		ST_RB    = 8'b0010_0000,  // first operand returns
		ST_EX    = 8'b0100_0000,  // second operand / load data returns
		ST_DONE  = 8'b1000_0000   // load result register
	} state_t;

	state_t state_q, state_d;

	// control state
	logic [7:0] pc_q, pc_d;
	logic       halt_q, halt_d;
	logic [7:0] start_q;
	logic       out_vld_q, out_vld_d;

	// working registers
	logic [7:0] ir0_q, ir0_d;
	logic [7:0] ir1_q, ir1_d;
	logic [7:0] opa_q, opa_d;
	logic [7:0] rd_q, rd_d;
	logic       exec_q, exec_d;
	brk_pkg::out_beat_t out_q, out_d;

	// main memory, one port; valid bits stand in for the cleared reset
	logic [7:0]   mem_q [256];
	logic [255:0] mem_vld_q;
	logic [7:0]   mem_rd_q;
	logic         mem_hit_q;
	logic         mem_we;
	logic [7:0]   mem_addr, mem_wdata;
	logic [7:0]   mem_byte;

	// register file, one read and one write port
	logic [7:0]  rf_q [16];
	logic [15:0] rf_vld_q;
	logic [7:0]  rf_rd_q;
	logic        rf_hit_q;
	logic        rf_we;
	logic [3:0]  rf_raddr, rf_waddr;
	logic [7:0]  rf_wdata;
	logic [7:0]  rf_byte;

	logic [3:0] op, fr, fs, ft;
	logic       in_take;

	assign op = ir0_q[7:4];
	assign fr = ir0_q[3:0];
	assign fs = ir1_q[7:4];
	assign ft = ir1_q[3:0];

	assign mem_byte = mem_hit_q ? mem_rd_q : 8'h00;
	assign rf_byte  = rf_hit_q ? rf_rd_q : 8'h00;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// sequencer
	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		halt_d    = halt_q;
		out_vld_d = out_vld_q && out_stall;
		ir0_d     = ir0_q;
		ir1_d     = ir1_q;
		opa_d     = opa_q;
		rd_d      = rd_q;
		exec_d    = exec_q;
		out_d     = out_q;
		mem_we    = 1'b0;
		mem_addr  = pc_q;
		mem_wdata = in_data.write_data;
		rf_we     = 1'b0;
		rf_raddr  = fr;
		rf_waddr  = fr;
		rf_wdata  = ir1_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					rd_d   = 8'h00;
					exec_d = 1'b0;
					unique case (in_data.mode)
						brk_pkg::MODE_WRITE: begin
							mem_we   = 1'b1;
							mem_addr = in_data.address;
							state_d  = ST_DONE;
						end
						brk_pkg::MODE_READ: begin
							mem_addr = in_data.address;
							state_d  = ST_HRD;
						end
						brk_pkg::MODE_RESTART: begin
							pc_d    = start_q;
							halt_d  = 1'b0;
							state_d = ST_DONE;
						end
						default: begin
							if (halt_q) begin
								state_d = ST_DONE;
							end else begin
								exec_d   = 1'b1;
								mem_addr = pc_q;
								state_d  = ST_F1;
							end
						end
					endcase
				end
			end
			ST_HRD: begin
				rd_d    = mem_byte;
				state_d = ST_DONE;
			end
			ST_F1: begin
				ir0_d    = mem_byte;
				mem_addr = pc_q + 8'd1;
				state_d  = ST_F2;
			end
			ST_F2: begin
				ir1_d   = mem_byte;
				pc_d    = pc_q + 8'd2;
				state_d = ST_DEC;
			end
			ST_DEC: begin
				state_d = ST_RB;
				unique case (op) inside
					brk_pkg::OP_LOAD: begin
						mem_addr = ir1_q;
						state_d  = ST_EX;
					end
					brk_pkg::OP_LDI: begin
						rf_we   = 1'b1;
						state_d = ST_DONE;
					end
					brk_pkg::OP_STORE, brk_pkg::OP_ROT, brk_pkg::OP_JMP: begin
						rf_raddr = fr;
					end
					brk_pkg::OP_MOVE, brk_pkg::OP_ADD, brk_pkg::OP_FADD,
					brk_pkg::OP_OR, brk_pkg::OP_AND, brk_pkg::OP_XOR: begin
						rf_raddr = fs;
					end
					default: begin
						halt_d  = 1'b1;
						state_d = ST_DONE;
					end
				endcase
			end
			ST_RB: begin
				opa_d   = rf_byte;
				state_d = ST_DONE;
				unique case (op)
					brk_pkg::OP_STORE: begin
						mem_we    = 1'b1;
						mem_addr  = ir1_q;
						mem_wdata = rf_byte;
					end
					brk_pkg::OP_MOVE: begin
						rf_we    = 1'b1;
						rf_waddr = ft;
						rf_wdata = rf_byte;
					end
					brk_pkg::OP_ROT: begin
						rf_we    = 1'b1;
						rf_wdata = brk_pkg::rotr8(rf_byte, ir1_q[2:0]);
					end
					brk_pkg::OP_JMP: begin
						rf_raddr = 4'h0;
						state_d  = ST_EX;
					end
					default: begin
						rf_raddr = ft;
						state_d  = ST_EX;
					end
				endcase
			end
			ST_EX: begin
				state_d = ST_DONE;
				rf_we   = 1'b1;
				case (op) inside
					brk_pkg::OP_LOAD: rf_wdata = mem_byte;
					brk_pkg::OP_ADD, brk_pkg::OP_FADD: rf_wdata = opa_q + rf_byte;
					brk_pkg::OP_OR:  rf_wdata = opa_q | rf_byte;
					brk_pkg::OP_AND: rf_wdata = opa_q & rf_byte;
					brk_pkg::OP_XOR: rf_wdata = opa_q ^ rf_byte;
					default: begin
						// conditional jump: compare Rr with R0
						rf_we = 1'b0;
						if (opa_q == rf_byte) begin
							pc_d = ir1_q;
						end
					end
				endcase
			end
			ST_DONE: begin
				// wait for a free output register
				if (!out_vld_q || !out_stall) begin
					out_vld_d             = 1'b1;
					out_d.read_data       = rd_q;
					out_d.program_counter = pc_q;
					out_d.halted          = halt_q;
					out_d.executed        = exec_q;
					state_d               = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= 8'h00;
			halt_q    <= 1'b0;
			start_q   <= 8'h00;
			out_vld_q <= 1'b0;
			mem_vld_q <= '0;
			rf_vld_q  <= '0;
		end else begin
			state_q   <= state_d;
			pc_q      <= pc_d;
			halt_q    <= halt_d;
			out_vld_q <= out_vld_d;
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end
			if (mem_we) begin
				mem_vld_q[mem_addr] <= 1'b1;
			end
			if (rf_we) begin
				rf_vld_q[rf_waddr] <= 1'b1;
			end
		end
	end

	// working registers, no reset
	always_ff @(posedge clk) begin
		ir0_q  <= ir0_d;
		ir1_q  <= ir1_d;
		opa_q  <= opa_d;
		rd_q   <= rd_d;
		exec_q <= exec_d;
		out_q  <= out_d;
	end

	// memory port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		mem_rd_q  <= mem_q[mem_addr];
		mem_hit_q <= mem_vld_q[mem_addr];
	end

	// register file ports
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_q[rf_waddr] <= rf_wdata;
		end
		rf_rd_q  <= rf_q[rf_raddr];
		rf_hit_q <= rf_vld_q[rf_raddr];
	end

endmodule

// ===== tb/sv/tb_brookshear_cpu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brookshear_cpu_core - self-checking bench for the Brookshear core
// Host beats (write, read, restart, step) go in through the input channel.
// A shadow copy of memory, registers, PC and halt flag predicts every result
// beat, which is then compared field by field. Directed programs come first,
// then random programs and noise across several start addresses, with random
// input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_brookshear_cpu_core;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 16;   // longer than the longest step
	localparam int RANDOM_ITEMS  = 1000;
	localparam int PHASES        = 8;

	// opcodes that stop the machine
	localparam logic [3:0] HALT_CODES [5] = '{4'h0, 4'hC, 4'hD, 4'hE, 4'hF};
	// start addresses for the first phases: both extremes, their neighbours and the midpoint
	localparam logic [7:0] START_POINTS [5] = '{8'hFF, 8'h00, 8'hFE, 8'h01, 8'h80};

	// ------------------------------------------------------------------------
	// Shadow machine: mirrors the architectural state and queues the result
	// beat each accepted command must produce.
	// ------------------------------------------------------------------------
	class machine_mirror;
		logic [7:0] mem [256];
		logic [7:0] regs [16];
		logic [7:0] pc;
		logic       halted;
		logic [7:0] start_pc;
		brk_pkg::out_beat_t due_results [$];
		int         errors;

		function new();
			foreach (mem[i]) mem[i] = '0;
			foreach (regs[i]) regs[i] = '0;
			pc       = '0;
			halted   = 1'b0;
			start_pc = '0;
			errors   = 0;
		endfunction

		function void set_start(logic [7:0] v);
			start_pc = v;
		endfunction

		// one instruction; PC is already past it when the op takes effect
		function void run_instruction();
			logic [7:0] b0, b1, next_pc, rs, rt, v;
			logic [3:0] op, r, s, t;
			logic [2:0] n;
			next_pc = pc + 8'd1;
			b0 = mem[pc];
			b1 = mem[next_pc];
			op = b0[7:4];
			r  = b0[3:0];
			s  = b1[7:4];
			t  = b1[3:0];
			rs = regs[s];
			rt = regs[t];
			pc = pc + 8'd2;
			case (op) inside
				brk_pkg::OP_LOAD:  regs[r] = mem[b1];
				brk_pkg::OP_LDI:   regs[r] = b1;
				brk_pkg::OP_STORE: mem[b1] = regs[r];
				brk_pkg::OP_MOVE:  regs[t] = rs;
				brk_pkg::OP_ADD, brk_pkg::OP_FADD: regs[r] = rs + rt;
				brk_pkg::OP_OR:    regs[r] = rs | rt;
				brk_pkg::OP_AND:   regs[r] = rs & rt;
				brk_pkg::OP_XOR:   regs[r] = rs ^ rt;
				brk_pkg::OP_ROT: begin
					v = regs[r];
					n = b1[2:0];
					// shift by 8 drops out, so a zero amount leaves v as is
					regs[r] = (v >> n) | (v << (4'd8 - n));
				end
				brk_pkg::OP_JMP: begin
					if (regs[r] == regs[0]) begin
						pc = b1;
					end
				end
				default: halted = 1'b1;
			endcase
		endfunction

		function void note_command(brk_pkg::in_beat_t c);
			brk_pkg::out_beat_t e;
			e = '0;
			case (c.mode)
				brk_pkg::MODE_WRITE:   mem[c.address] = c.write_data;
				brk_pkg::MODE_READ:    e.read_data = mem[c.address];
				brk_pkg::MODE_RESTART: begin
					pc     = start_pc;
					halted = 1'b0;
				end
				default: begin
					if (!halted) begin
						run_instruction();
						e.executed = 1'b1;
					end
				end
			endcase
			e.program_counter = pc;
			e.halted          = halted;
			due_results.push_back(e);
		endfunction

		function void match_field(string what, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %02h, got %02h", $time, what, want, got);
			end
		endfunction

		function void check_result(brk_pkg::out_beat_t got);
			brk_pkg::out_beat_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: result beat %h with nothing expected", $time, got);
				return;
			end
			want = due_results.pop_front();
			match_field("read_data", want.read_data, got.read_data);
			match_field("program_counter", want.program_counter, got.program_counter);
			match_field("halted", {7'd0, want.halted}, {7'd0, got.halted});
			match_field("executed", {7'd0, want.executed}, {7'd0, got.executed});
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup; every input starts at a known value
	// ------------------------------------------------------------------------
	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	brk_pkg::in_beat_t  in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	brk_pkg::out_beat_t out_data;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = '0;

	int          send_gap_pct = 25;  // chance of an input gap before a beat
	int          stall_pct    = 25;  // chance of an output stall burst
	bit          quiet_tail   = 1'b0; // no gaps or stalls in the last phase
	int          items_sent   = 0;
	int unsigned cycle_count  = 0;

	machine_mirror mirror = new();

	brookshear_cpu_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d results still due", $time, mirror.due_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Result side: check each accepted beat, then pick the next stall value.
	// Signals are sampled right after the edge, i.e. their pre-edge values.
	// ------------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				mirror.check_result(out_data);
			end
			if (stall_left > 0) begin
				stall_left--;
			end else if (!quiet_tail && arst_n && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 6);
			end
			out_stall <= (stall_left != 0);
		end
	end

	// ------------------------------------------------------------------------
	// Command side
	// ------------------------------------------------------------------------

	// one beat; valid stays up after acceptance so back-to-back beats need
	// no extra assignment in the same step
	task automatic send_command(logic [1:0] mode, logic [7:0] addr, logic [7:0] data);
		brk_pkg::in_beat_t beat;
		int gap;
		beat.mode       = mode;
		beat.address    = addr;
		beat.write_data = data;
		if (!quiet_tail && $urandom_range(0, 99) < send_gap_pct) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (in_stall);
		mirror.note_command(beat);
		items_sent++;
	endtask

	task automatic send_steps(int n);
		repeat (n) send_command(brk_pkg::MODE_STEP, 8'($urandom), 8'($urandom));
	endtask

	task automatic send_restart();
		send_command(brk_pkg::MODE_RESTART, 8'($urandom), 8'($urandom));
	endtask

	// lay 16-bit instruction words down from base, wrapping at 256
	task automatic load_words(logic [7:0] base, logic [15:0] words [$]);
		logic [7:0] a;
		a = base;
		foreach (words[i]) begin
			send_command(brk_pkg::MODE_WRITE, a, words[i][15:8]);
			send_command(brk_pkg::MODE_WRITE, a + 8'd1, words[i][7:0]);
			a = a + 8'd2;
		end
	endtask

	// idle input, let every due beat come back, then cover the last step
	task automatic drain_results();
		in_valid <= 1'b0;
		while (mirror.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_start(logic [7:0] v);
		drain_results();
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.set_start(v);
	endtask

	// mostly real ops; jumps often aim back into the program itself
	function automatic logic [15:0] random_instruction(logic [7:0] base, int words);
		logic [3:0] op;
		logic [3:0] reg_r;
		logic [7:0] lo;
		if ($urandom_range(0, 99) < 12) begin
			op = HALT_CODES[$urandom_range(0, 4)];
		end else begin
			op = 4'($urandom_range(brk_pkg::OP_LOAD, brk_pkg::OP_JMP));
		end
		reg_r = 4'($urandom_range(0, 15));
		lo    = 8'($urandom);
		if (op == brk_pkg::OP_JMP && $urandom_range(0, 1) == 1) begin
			lo = base + 8'(2 * $urandom_range(0, words - 1));
		end
		return {op, reg_r, lo};
	endfunction

	// well-formed run: load, seed some data, restart, step up to three past the word count
	task automatic run_program(logic [7:0] base);
		logic [15:0] words [$];
		int count;
		count = $urandom_range(2, 8);
		repeat (count) words.push_back(random_instruction(base, count));
		load_words(base, words);
		repeat ($urandom_range(0, 2)) begin
			send_command(brk_pkg::MODE_WRITE, 8'($urandom), 8'($urandom));
		end
		send_restart();
		send_steps(count + $urandom_range(0, 3));
		repeat ($urandom_range(0, 2)) begin
			send_command(brk_pkg::MODE_READ, 8'($urandom), 8'($urandom));
		end
	endtask

	// any mode, any fields
	task automatic noise_burst();
		repeat ($urandom_range(1, 6)) begin
			send_command(2'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0] start;
		int target;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, start address at its reset value of zero.
		// Cleared memory holds opcode 0: first step halts, second is a no-op.
		send_steps(2);
		// host access at the top address, both data extremes
		send_command(brk_pkg::MODE_READ, 8'hFF, 8'h00);
		send_command(brk_pkg::MODE_WRITE, 8'hFF, 8'hFF);
		send_command(brk_pkg::MODE_READ, 8'hFF, 8'h00);
		send_command(brk_pkg::MODE_WRITE, 8'hFF, 8'h00);
		// every opcode once: immediates, rotate by 7 and by 8 (i.e. none),
		// add wrap, logic ops, move, store/load round trip, jump taken and
		// not taken, with a halt skipped by the taken jump
		load_words(8'h00, '{16'h21FF, 16'h2281, 16'hA207, 16'hA108, 16'h5312,
			16'h6412, 16'h7512, 16'h8612, 16'h9712, 16'h4018, 16'h31FE, 16'h19FE,
			16'hB01C, 16'hC000, 16'hB100, 16'hD000});
		// restart clears the earlier halt
		send_restart();
		send_steps(16);
		send_command(brk_pkg::MODE_READ, 8'hFE, 8'h00);

		// Random part: phases with their own start address and idle mix
		for (int phase = 0; phase < PHASES; phase++) begin
			start = (phase < 5) ? START_POINTS[phase] : 8'($urandom);
			case (phase % 3)
				0: begin
					send_gap_pct = 0;
					stall_pct    = 30;
				end
				1: begin
					send_gap_pct = 20;
					stall_pct    = 0;
				end
				default: begin
					send_gap_pct = 45;
					stall_pct    = 45;
				end
			endcase
			quiet_tail = (phase == PHASES - 1);
			write_start(start);
			target = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < target) begin
				if ($urandom_range(0, 99) < 80) begin
					run_program(start);
				end else begin
					noise_burst();
				end
			end
		end

		drain_results();
		if (mirror.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/brk_pkg.sv
hw/rtl/brookshear_cpu_core.sv
tb/sv/tb_brookshear_cpu_core.sv
